/* rtl/kbse_pkg.sv */
// ----------------------------------------------------------------------------
// kbse_pkg: keypad BCD setpoint entry shared definitions
// Key codes, decoded command and result record used across the unit.
// ----------------------------------------------------------------------------
package kbse_pkg;

    localparam int KeyWidth   = 5;
    localparam int DigitWidth = 4;
    localparam int ValueWidth = 14;

    // Scanned key codes with a function of their own
    localparam logic [KeyWidth-1:0] KEY_INC    = 5'd3;
    localparam logic [KeyWidth-1:0] KEY_DEC    = 5'd7;
    localparam logic [KeyWidth-1:0] KEY_TOGGLE = 5'd11;
    localparam logic [KeyWidth-1:0] KEY_ZERO   = 5'd13;
    localparam logic [KeyWidth-1:0] KEY_APPLY  = 5'd15;

    localparam logic [DigitWidth-1:0] DIGIT_MAX      = 4'd9;
    localparam logic [DigitWidth-1:0] THOUSANDS_WRAP = 4'd5;
    localparam logic [DigitWidth-1:0] THOUSANDS_TOP  = 4'd4;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_DIGIT,
        ACT_INC,
        ACT_DEC,
        ACT_TOGGLE,
        ACT_APPLY
    } kbse_action_t;

    typedef struct packed {
        kbse_action_t            action;
        logic [DigitWidth-1:0]   digit;
    } kbse_cmd_t;

    typedef struct packed {
        logic [DigitWidth-1:0]   thousands;
        logic [DigitWidth-1:0]   hundreds;
        logic [DigitWidth-1:0]   tens;
        logic [DigitWidth-1:0]   ones;
        logic                    capture;
        logic                    apply;
        logic [ValueWidth-1:0]   value;
    } kbse_result_t;

endpackage

/* rtl/kbse_key_if.sv */
// ----------------------------------------------------------------------------
// kbse_key_if: key item channel
// Valid/ready channel that carries one scanned key code per item.
// ----------------------------------------------------------------------------
interface kbse_key_if
    import kbse_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [KeyWidth-1:0] key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

/* rtl/kbse_result_if.sv */
// ----------------------------------------------------------------------------
// kbse_result_if: setpoint result channel
// Valid/ready channel that carries the digits, flag and DAC write per item.
// ----------------------------------------------------------------------------
interface kbse_result_if
    import kbse_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [DigitWidth-1:0] digit_thousands;
    logic [DigitWidth-1:0] digit_hundreds;
    logic [DigitWidth-1:0] digit_tens;
    logic [DigitWidth-1:0] digit_ones;
    logic                  capture_enable;
    logic                  dac_write;
    logic [ValueWidth-1:0] dac_value;

    modport source (
        output valid, input ready,
        output digit_thousands, output digit_hundreds, output digit_tens,
        output digit_ones, output capture_enable, output dac_write, output dac_value
    );
    modport sink (
        input valid, output ready,
        input digit_thousands, input digit_hundreds, input digit_tens,
        input digit_ones, input capture_enable, input dac_write, input dac_value
    );
endinterface

/* rtl/kbse_decode.sv */
// ----------------------------------------------------------------------------
// kbse_decode: key code decoder
// Map a scanned key code onto a command and the digit it enters.
// ----------------------------------------------------------------------------
module kbse_decode
    import kbse_pkg::*;
(
    input  logic [KeyWidth-1:0] key_code,
    output kbse_cmd_t           cmd
);

    always_comb
    begin
        cmd.action = ACT_NONE;
        cmd.digit  = '0;
        case (key_code)
            5'd0, 5'd1, 5'd2:
            begin
                cmd.action = ACT_DIGIT;
                cmd.digit  = DigitWidth'(key_code + 5'd1);
            end
            5'd4, 5'd5, 5'd6:
            begin
                cmd.action = ACT_DIGIT;
                cmd.digit  = key_code[DigitWidth-1:0];
            end
            5'd8, 5'd9, 5'd10:
            begin
                cmd.action = ACT_DIGIT;
                cmd.digit  = DigitWidth'(key_code - 5'd1);
            end
            KEY_ZERO:   cmd.action = ACT_DIGIT;
            KEY_INC:    cmd.action = ACT_INC;
            KEY_DEC:    cmd.action = ACT_DEC;
            KEY_TOGGLE: cmd.action = ACT_TOGGLE;
            KEY_APPLY:  cmd.action = ACT_APPLY;
            default:    cmd.action = ACT_NONE;
        endcase
    end

endmodule

/* rtl/kbse_digits.sv */
// ----------------------------------------------------------------------------
// kbse_digits: setpoint digit store
// Hold the four digits and capture flag; apply one command per enable.
// ----------------------------------------------------------------------------
module kbse_digits
    import kbse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  kbse_cmd_t    cmd,
    output kbse_result_t result
);

    logic [DigitWidth-1:0] thousands_reg, hundreds_reg, tens_reg, ones_reg;
    logic [DigitWidth-1:0] thousands_next, hundreds_next, tens_next, ones_next;
    logic                  capture_reg, capture_next;

    // Carry and borrow chains: each digit moves only when every digit below wraps
    logic inc_c1, inc_c2, inc_c3;
    logic dec_b1, dec_b2, dec_b3;
    logic [DigitWidth-1:0] th_inc;

    assign inc_c1 = (ones_reg >= DIGIT_MAX);
    assign inc_c2 = inc_c1 && (tens_reg >= DIGIT_MAX);
    assign inc_c3 = inc_c2 && (hundreds_reg >= DIGIT_MAX);
    assign dec_b1 = (ones_reg == '0);
    assign dec_b2 = dec_b1 && (tens_reg == '0);
    assign dec_b3 = dec_b2 && (hundreds_reg == '0);
    assign th_inc = thousands_reg + 4'd1;

    always_comb
    begin
        thousands_next = thousands_reg;
        hundreds_next  = hundreds_reg;
        tens_next      = tens_reg;
        ones_next      = ones_reg;
        capture_next   = capture_reg;
        case (cmd.action)
            ACT_DIGIT:
            begin
                thousands_next = hundreds_reg;
                hundreds_next  = tens_reg;
                tens_next      = ones_reg;
                ones_next      = cmd.digit;
            end
            ACT_INC:
            begin
                ones_next = inc_c1 ? 4'd0 : ones_reg + 4'd1;
                if (inc_c1)
                begin
                    tens_next = inc_c2 ? 4'd0 : tens_reg + 4'd1;
                end
                if (inc_c2)
                begin
                    hundreds_next = inc_c3 ? 4'd0 : hundreds_reg + 4'd1;
                end
                if (inc_c3)
                begin
                    thousands_next = (th_inc >= THOUSANDS_WRAP) ? 4'd0 : th_inc;
                end
            end
            ACT_DEC:
            begin
                ones_next = dec_b1 ? DIGIT_MAX : ones_reg - 4'd1;
                if (dec_b1)
                begin
                    tens_next = dec_b2 ? DIGIT_MAX : tens_reg - 4'd1;
                end
                if (dec_b2)
                begin
                    hundreds_next = dec_b3 ? DIGIT_MAX : hundreds_reg - 4'd1;
                end
                if (dec_b3)
                begin
                    thousands_next = (thousands_reg == '0) ? THOUSANDS_TOP
                                                           : thousands_reg - 4'd1;
                end
            end
            ACT_TOGGLE: capture_next = ~capture_reg;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thousands_reg <= '0;
            hundreds_reg  <= '0;
            tens_reg      <= '0;
            ones_reg      <= '0;
            capture_reg   <= 1'b0;
        end
        else if (en)
        begin
            thousands_reg <= thousands_next;
            hundreds_reg  <= hundreds_next;
            tens_reg      <= tens_next;
            ones_reg      <= ones_next;
            capture_reg   <= capture_next;
        end
    end

    always_comb
    begin
        result.thousands = thousands_next;
        result.hundreds  = hundreds_next;
        result.tens      = tens_next;
        result.ones      = ones_next;
        result.capture   = capture_next;
        result.apply     = (cmd.action == ACT_APPLY);
        result.value     = ValueWidth'({10'd0, thousands_next} * 14'd1000)
                         + ValueWidth'({10'd0, hundreds_next} * 14'd100)
                         + ValueWidth'({10'd0, tens_next} * 14'd10)
                         + {10'd0, ones_next};
    end

endmodule

/* rtl/keypad_bcd_setpoint_entry_unit.sv */
// ----------------------------------------------------------------------------
// keypad_bcd_setpoint_entry_unit: keypad setpoint entry top level
// Turn scanned key codes into a four-digit decimal setpoint, a capture flag
// and DAC write requests carrying the binary value of the setpoint.
// ----------------------------------------------------------------------------
//
//   channel   role      payload
//   -------   -------   ---------------------------------------------------
//   keys      sink      key_code (5b)
//   result    source    digit_thousands/hundreds/tens/ones (4b each),
//                       capture_enable, dac_write, dac_value (14b)
//
// Each key item passes through the key register, then through the decode and
// digit update into the result register.
// One item is accepted every cycle while the result side keeps taking items.
// Reset clears the digits, the capture flag and both valid flags.
// A stall on the result side holds the result register, then the key
// register, then drops keys.ready; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module keypad_bcd_setpoint_entry_unit
    import kbse_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    kbse_key_if.sink             keys,
    kbse_result_if.source        result
);

    // Key register stage
    logic                key_valid_reg;
    logic [KeyWidth-1:0] key_code_reg;

    // Result register stage
    logic                out_valid_reg;
    kbse_result_t        out_reg;

    logic         out_free;
    logic         advance;
    kbse_cmd_t    cmd;
    kbse_result_t result_next;

    // Advance the key register into the result register when the result slot
    // is empty or is being taken this cycle.
    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = key_valid_reg && out_free;
    assign keys.ready = !key_valid_reg || out_free;

    kbse_decode u_decode (
        .key_code (key_code_reg),
        .cmd      (cmd)
    );

    // Digit state commits only when its item moves into the result register,
    // so the order of state updates follows the order of items.
    kbse_digits u_digits (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .cmd    (cmd),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (keys.ready)
            begin
                key_valid_reg <= keys.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= key_valid_reg;
            end
        end
    end

    // Payload registers: load only on a move, no reset needed
    always_ff @(posedge clk)
    begin
        if (keys.valid && keys.ready)
        begin
            key_code_reg <= keys.key_code;
        end
        if (advance)
        begin
            out_reg <= result_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.digit_thousands = out_reg.thousands;
    assign result.digit_hundreds  = out_reg.hundreds;
    assign result.digit_tens      = out_reg.tens;
    assign result.digit_ones      = out_reg.ones;
    assign result.capture_enable  = out_reg.capture;
    assign result.dac_write       = out_reg.apply;
    assign result.dac_value       = out_reg.value;

endmodule

/* sim/tb_keypad_bcd_setpoint_entry_unit.sv */
// ----------------------------------------------------------------------------
// tb_keypad_bcd_setpoint_entry_unit: self-checking bench for setpoint entry
// Sends scanned key codes into the unit and predicts, for every key item, the
// digits, capture flag, DAC write and binary value that must come back. First
// comes a directed set of keys for the carry, borrow and wrap corners, then
// random digit entries followed by runs of increments and decrements, mixed
// with key noise. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_keypad_bcd_setpoint_entry_unit
    import kbse_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Key codes that do nothing, so that stimulus writes them by name
    localparam logic [KeyWidth-1:0] KEY_SPARE_A   = 5'd12;
    localparam logic [KeyWidth-1:0] KEY_SPARE_B   = 5'd14;
    localparam logic [KeyWidth-1:0] KEY_IDLE_LOW  = 5'd16;
    localparam logic [KeyWidth-1:0] KEY_IDLE_HIGH = 5'd31;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRINT_LIMIT    = 40;
    localparam int DRAIN_CYCLES   = 8;

    // ------------------------------------------------------------------------
    // Setpoint predictor and store of expected results
    // ------------------------------------------------------------------------
    class setpoint_scoreboard;
        logic [DigitWidth-1:0] thousands;
        logic [DigitWidth-1:0] hundreds;
        logic [DigitWidth-1:0] tens;
        logic [DigitWidth-1:0] ones;
        logic                  capture;
        kbse_result_t          pending[$];
        int unsigned           mismatches;
        int unsigned           checked;
        int unsigned           dac_writes;
        int unsigned           thousands_wraps;

        function new();
            thousands       = '0;
            hundreds        = '0;
            tens            = '0;
            ones            = '0;
            capture         = 1'b0;
            mismatches      = 0;
            checked         = 0;
            dac_writes      = 0;
            thousands_wraps = 0;
        endfunction

        function void shift_digit(logic [DigitWidth-1:0] d);
            thousands = hundreds;
            hundreds  = tens;
            tens      = ones;
            ones      = d;
        endfunction

        // Add one; the carry reaches thousands only through the hundreds digit
        function void count_up();
            if (ones >= DIGIT_MAX) begin
                ones = '0;
                if (tens >= DIGIT_MAX) begin
                    tens = '0;
                    if (hundreds >= DIGIT_MAX) begin
                        hundreds  = '0;
                        thousands = thousands + 1'b1;
                        if (thousands >= THOUSANDS_WRAP) begin
                            thousands = '0;
                            thousands_wraps++;
                        end
                    end
                    else
                        hundreds = hundreds + 1'b1;
                end
                else
                    tens = tens + 1'b1;
            end
            else
                ones = ones + 1'b1;
        endfunction

        function void count_down();
            if (ones == 0) begin
                ones = DIGIT_MAX;
                if (tens == 0) begin
                    tens = DIGIT_MAX;
                    if (hundreds == 0) begin
                        hundreds = DIGIT_MAX;
                        if (thousands == 0) begin
                            thousands = THOUSANDS_TOP;
                            thousands_wraps++;
                        end
                        else
                            thousands = thousands - 1'b1;
                    end
                    else
                        hundreds = hundreds - 1'b1;
                end
                else
                    tens = tens - 1'b1;
            end
            else
                ones = ones - 1'b1;
        endfunction

        // Advance the setpoint by one accepted key and queue what must come out
        function void note_key(logic [KeyWidth-1:0] code);
            kbse_result_t want;
            int           value;

            want.apply = 1'b0;
            if (code == KEY_INC)
                count_up();
            else if (code == KEY_DEC)
                count_down();
            else if (code == KEY_TOGGLE)
                capture = ~capture;
            else if (code == KEY_APPLY)
                want.apply = 1'b1;
            else if (code == KEY_ZERO)
                shift_digit('0);
            else if (code < KEY_INC)
                shift_digit(DigitWidth'(code + 1));
            else if (code > KEY_INC && code < KEY_DEC)
                shift_digit(DigitWidth'(code));
            else if (code > KEY_DEC && code < KEY_TOGGLE)
                shift_digit(DigitWidth'(code - 1));

            value = thousands * 1000 + hundreds * 100 + tens * 10 + ones;
            want.thousands = thousands;
            want.hundreds  = hundreds;
            want.tens      = tens;
            want.ones      = ones;
            want.capture   = capture;
            want.value     = ValueWidth'(value);
            if (want.apply)
                dac_writes++;
            pending.push_back(want);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] result %0d %s: got %0d, expected %0d",
                         $realtime, checked, what, got, want);
        endtask

        task check_result(kbse_result_t got);
            kbse_result_t want;

            if (pending.size() == 0) begin
                report_mismatch("unexpected result", 32'(got.value), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.thousands !== want.thousands)
                report_mismatch("digit_thousands", 32'(got.thousands),
                                32'(want.thousands));
            if (got.hundreds !== want.hundreds)
                report_mismatch("digit_hundreds", 32'(got.hundreds),
                                32'(want.hundreds));
            if (got.tens !== want.tens)
                report_mismatch("digit_tens", 32'(got.tens), 32'(want.tens));
            if (got.ones !== want.ones)
                report_mismatch("digit_ones", 32'(got.ones), 32'(want.ones));
            if (got.capture !== want.capture)
                report_mismatch("capture_enable", 32'(got.capture),
                                32'(want.capture));
            if (got.apply !== want.apply)
                report_mismatch("dac_write", 32'(got.apply), 32'(want.apply));
            if (got.value !== want.value)
                report_mismatch("dac_value", 32'(got.value), 32'(want.value));
            checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the unit under test
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;

    kbse_key_if    keys_ch ();
    kbse_result_if result_ch ();

    keypad_bcd_setpoint_entry_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .keys   (keys_ch),
        .result (result_ch)
    );

    setpoint_scoreboard board = new();

    // Idling on both channels is allowed only while this is set
    bit           idle_on;
    int           sink_stall_left;
    int unsigned  keys_sent;
    int unsigned  cycle_count;
    kbse_result_t seen_result;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Drive every input to a known value before the first edge
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        keys_ch.valid    = 1'b0;
        keys_ch.key_code = '0;
        result_ch.ready  = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: check each accepted result, then pick the next ready.
    // Everything sampled here is the value from before the edge, since the
    // unit updates its outputs from flops and this bench drives with NBAs.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready) begin
            seen_result = {result_ch.digit_thousands, result_ch.digit_hundreds,
                           result_ch.digit_tens, result_ch.digit_ones,
                           result_ch.capture_enable, result_ch.dac_write,
                           result_ch.dac_value};
            board.check_result(seen_result);
        end
        // Start a stall burst now and then, hold ready low through it
        if (idle_on && sink_stall_left == 0 && $urandom_range(0, 9) == 0)
            sink_stall_left = $urandom_range(1, 8);
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Key side
    // ------------------------------------------------------------------------
    function automatic logic [KeyWidth-1:0] key_for_digit(int d);
        if (d == 0)
            return KEY_ZERO;
        else if (d <= 3)
            return KeyWidth'(d - 1);
        else if (d <= 6)
            return KeyWidth'(d);
        else
            return KeyWidth'(d + 1);
    endfunction

    // Keys the unit merely ignores do not count toward the item budget
    function automatic bit is_live_key(logic [KeyWidth-1:0] code);
        return code < KEY_IDLE_LOW && code != KEY_SPARE_A && code != KEY_SPARE_B;
    endfunction

    // Favor 9 and 0 so that carries and borrows chain often
    function automatic int pick_digit();
        int r;

        r = $urandom_range(0, 9);
        if (r < 2)
            return 9;
        else if (r < 4)
            return 0;
        else
            return $urandom_range(0, 9);
    endfunction

    // Offer one key item, maybe after an idle burst, and hold it until taken
    task automatic push_key(logic [KeyWidth-1:0] code);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            keys_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        keys_ch.valid    <= 1'b1;
        keys_ch.key_code <= code;
        @(posedge clk);
        while (!keys_ch.ready)
            @(posedge clk);
        board.note_key(code);
        if (is_live_key(code))
            keys_sent++;
    endtask

    // Hold off the key side until every expected result has come back
    task automatic drain_results();
        keys_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    // Mostly digit entries followed by a run of commands; the rest is noise
    task automatic random_keys(int unsigned count);
        int unsigned goal;
        int          r;

        goal = keys_sent + count;
        while (keys_sent < goal) begin
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, 4))
                    push_key(key_for_digit(pick_digit()));
                repeat ($urandom_range(1, 6)) begin
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        push_key(KEY_INC);
                    else if (r < 8)
                        push_key(KEY_DEC);
                    else if (r == 8)
                        push_key(KEY_TOGGLE);
                    else
                        push_key(KEY_APPLY);
                end
            end
            else begin
                repeat ($urandom_range(1, 4))
                    push_key(KeyWidth'($urandom_range(0, 31)));
            end
            if ($urandom_range(0, 59) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Watchdog: end the run if results stop coming
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, board.pending.size());
        $display("keypad_bcd_setpoint_entry_unit: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        idle_on         = 1'b0;
        sink_stall_left = 0;
        keys_sent       = 0;

        // Hold reset low, then release it on an edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners, no idling. Borrow from zero wraps thousands to 4,
        // and the increment after it wraps thousands from 4 back to 0.
        push_key(KEY_DEC);
        push_key(KEY_INC);
        // Build 9999 by entry, write it out, then carry all the way through
        // the hundreds digit with a thousands digit far above 4
        repeat (4) push_key(key_for_digit(9));
        push_key(KEY_APPLY);
        push_key(KEY_INC);
        push_key(KEY_TOGGLE);
        // Walk digit keys 1 to 8 and 0 once; thousands ends up above 4 by entry
        push_key(key_for_digit(1));
        push_key(key_for_digit(2));
        push_key(key_for_digit(3));
        push_key(key_for_digit(4));
        push_key(key_for_digit(5));
        push_key(key_for_digit(6));
        push_key(key_for_digit(7));
        push_key(key_for_digit(8));
        push_key(key_for_digit(0));
        push_key(KEY_DEC);
        // Unused keys and the no-key range must leave everything alone
        push_key(KEY_SPARE_A);
        push_key(KEY_SPARE_B);
        push_key(KEY_IDLE_LOW);
        push_key(KEY_IDLE_HIGH);
        push_key(KEY_TOGGLE);
        push_key(KEY_APPLY);

        // Stop sending until the unit has answered everything so far
        drain_results();

        // Random phases: idling on, a calm stretch, idling again, and a
        // final part that runs back to back on both sides
        idle_on = 1'b1;
        random_keys(300);
        idle_on = 1'b0;
        random_keys(150);
        idle_on = 1'b1;
        random_keys(250);
        drain_results();
        idle_on = 1'b0;
        random_keys(150);

        // Wait for the last results, then watch for strays a little longer
        keys_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results from %0d live keys in %0d cycles",
                 board.checked, keys_sent, cycle_count);
        $display("%0d DAC writes, %0d thousands wraps, %0d field mismatches",
                 board.dac_writes, board.thousands_wraps, board.mismatches);
        if (board.mismatches == 0)
            $display("keypad_bcd_setpoint_entry_unit: match");
        else
            $display("keypad_bcd_setpoint_entry_unit: mismatch");
        $finish;
    end

endmodule
